### hdl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg: shared types and constants of the five-point stencil update
// Holds the data widths, the register indexes of the configuration port and
// the window column type that the cells pass along the chain.
// ----------------------------------------------------------------------------
package fps_pkg;

  // Cell value width, unsigned Q16.16.
  localparam int DATA_W = 32;

  // Width of the widened stencil sum: 4*centre plus four neighbors.
  localparam int SUM_W = DATA_W + 3;

  // Width of a size register.
  localparam int CFG_W = 11;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  // One column of the 3x3 window: top is the oldest row.
  typedef struct packed {
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] mid;
    logic [DATA_W-1:0] bot;
  } col_t;

endpackage

### hdl/fps_cell.sv
// ----------------------------------------------------------------------------
// fps_cell: one column cell of the stencil window
// Holds one window column and takes the column of its right-hand neighbor
// on every beat that moves the window.
// ----------------------------------------------------------------------------
module fps_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  fps_pkg::col_t col_in,
  output fps_pkg::col_t col_r
);

  fps_pkg::col_t col_nxt;

  // Load the neighbor column when the window moves.
  always_comb begin
    col_nxt = col_r;
    if (shift_en) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

endmodule

### hdl/fps_line.sv
// ----------------------------------------------------------------------------
// fps_line: line store of the stencil window
// Simple dual-port memory with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fps_line #(
  parameter int DEPTH = 1026,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [fps_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [fps_pkg::DATA_W-1:0] rdata_r
);

  logic [fps_pkg::DATA_W-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### hdl/five_point_stencil_update.sv
// ----------------------------------------------------------------------------
// five_point_stencil_update: streaming five-point Jacobi update
// Takes a framed plane in raster order, keeps two line stores and a 3x3
// window built from a chain of three column cells, and emits
// (4*centre + N + S + E + W) >> 3 for every interior cell.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_cell_value
//   out      output     out_valid/out_ready  out_new_value, out_plane_done
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One cell beat is taken per cycle unless the output stalls; a result passes
// the line store read, the window move and the sum into the output register.
// The line stores have one read and one write port per store.
// Reset clears the counters, the window and the pipeline; the line stores
// are not cleared and need no clearing pass.
// Input beats stop only while a result waits in the output register and the
// next result is ready behind it; halo beats keep flowing otherwise.
// ----------------------------------------------------------------------------
module five_point_stencil_update #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fps_pkg::DATA_W-1:0]    in_cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fps_pkg::DATA_W-1:0]    out_new_value,
  output logic                          out_plane_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fps_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_COLS + 2;
  localparam int CW    = $clog2(MAX_COLS + 2);
  localparam int RW    = $clog2(MAX_ROWS + 2);
  localparam int CXC   = (CW > fps_pkg::CFG_W) ? CW : fps_pkg::CFG_W;
  localparam int CXR   = (RW > fps_pkg::CFG_W) ? RW : fps_pkg::CFG_W;

  // Configuration registers.
  logic [fps_pkg::CFG_W-1:0] cols_r, cols_nxt;
  logic [fps_pkg::CFG_W-1:0] rows_r, rows_nxt;

  // Raster position of the next framed cell.
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;

  // Effective sizes and last framed positions.
  logic [CXC-1:0] cols_x;
  logic [CXR-1:0] rows_x;
  logic [CW-1:0]  cols_lim;
  logic [RW-1:0]  rows_lim;

  // Line store read stage.
  logic                       s1_v_r, s1_v_nxt;
  logic [fps_pkg::DATA_W-1:0] s1_cell_r;
  logic [CW-1:0]              s1_addr_r;
  logic                       s1_emit_r, s1_done_r;

  // Window stage: a result is pending in the window.
  logic s2_v_r, s2_v_nxt;
  logic s2_done_r;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic [fps_pkg::DATA_W-1:0] out_new_value_r;
  logic                       out_plane_done_r;

  logic                       stall, adv, in_acc, cfg_acc, shift_en, load_out;
  logic [fps_pkg::DATA_W-1:0] upper_rd, middle_rd;
  logic [fps_pkg::SUM_W-1:0]  sum;
  fps_pkg::col_t              col_w [0:3];

  // Clamp the size registers to the supported range.
  always_comb begin
    cols_x = CXC'(cols_r);
    if (cols_x == '0) begin
      cols_x = CXC'(1);
    end else if (cols_x > CXC'(MAX_COLS)) begin
      cols_x = CXC'(MAX_COLS);
    end
    rows_x = CXR'(rows_r);
    if (rows_x == '0) begin
      rows_x = CXR'(1);
    end else if (rows_x > CXR'(MAX_ROWS)) begin
      rows_x = CXR'(MAX_ROWS);
    end
    cols_lim = CW'(cols_x) + CW'(1);
    rows_lim = RW'(rows_x) + RW'(1);
  end

  // Flow control: only a pending result behind a blocked output stops things.
  assign stall     = out_valid_r && !out_ready && s2_v_r;
  assign adv       = !stall;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign shift_en  = adv && s1_v_r;
  assign load_out  = adv && s2_v_r;

  // Configuration writes and raster counters.
  always_comb begin
    cols_nxt    = cols_r;
    rows_nxt    = rows_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_acc) begin
      unique case (cfg_index)
        fps_pkg::REG_COLS: begin
          cols_nxt    = cfg_data;
          col_cnt_nxt = '0;
          row_cnt_nxt = '0;
        end
        fps_pkg::REG_ROWS: begin
          rows_nxt    = cfg_data;
          col_cnt_nxt = '0;
          row_cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (col_cnt_r >= cols_lim) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row_cnt_r >= rows_lim) ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  // Pipeline valid flags and output register control.
  always_comb begin
    s1_v_nxt      = s1_v_r;
    s2_v_nxt      = s2_v_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      s1_v_nxt = in_acc;
      s2_v_nxt = s1_v_r && s1_emit_r;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= fps_pkg::CFG_W'(1024);
      rows_r      <= fps_pkg::CFG_W'(1024);
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the read stage, tagged with the result flags of its position.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cell_r <= in_cell_value;
      s1_addr_r <= col_cnt_r;
      s1_emit_r <= (row_cnt_r >= RW'(2)) && (col_cnt_r >= CW'(2));
      s1_done_r <= (row_cnt_r == rows_lim) && (col_cnt_r == cols_lim);
    end
    if (shift_en) begin
      s2_done_r <= s1_done_r;
    end
  end

  // Line stores: the upper store takes the middle row, the middle store the
  // arriving cell, at the column of the beat in the read stage.
  fps_line #(.DEPTH(DEPTH), .AW(CW)) u_upper (
    .clk     (clk),
    .we      (shift_en),
    .waddr   (s1_addr_r),
    .wdata   (middle_rd),
    .re      (in_acc),
    .raddr   (col_cnt_r),
    .rdata_r (upper_rd)
  );

  fps_line #(.DEPTH(DEPTH), .AW(CW)) u_middle (
    .clk     (clk),
    .we      (shift_en),
    .waddr   (s1_addr_r),
    .wdata   (s1_cell_r),
    .re      (in_acc),
    .raddr   (col_cnt_r),
    .rdata_r (middle_rd)
  );

  // Window: the new column enters the right-hand cell and moves left.
  assign col_w[3] = '{top: upper_rd, mid: middle_rd, bot: s1_cell_r};

  for (genvar k = 0; k < 3; k++) begin : g_cell
    fps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .col_in   (col_w[k+1]),
      .col_r    (col_w[k])
    );
  end

  // Widened stencil sum around the centre of the window.
  assign sum = fps_pkg::SUM_W'({col_w[1].mid, 2'b00})
             + fps_pkg::SUM_W'(col_w[1].top)
             + fps_pkg::SUM_W'(col_w[1].bot)
             + fps_pkg::SUM_W'(col_w[0].mid)
             + fps_pkg::SUM_W'(col_w[2].mid);

  // Output register: the sum is truncated by three bits.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_new_value_r  <= sum[fps_pkg::SUM_W-1:3];
      out_plane_done_r <= s2_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_value  = out_new_value_r;
  assign out_plane_done = out_plane_done_r;

`ifndef SYNTHESIS
  // A result enters the output register only from a pending window result.
  a_out_from_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(s2_v_r))
    else $error("output beat without a pending window result");

  // The raster counters never pass the framed plane.
  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (col_cnt_r <= cols_lim) && (row_cnt_r <= rows_lim))
    else $error("raster counter beyond the framed plane");

  // The window holds while its pending result cannot leave.
  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(col_w[1].mid) && $stable(col_w[0].mid))
    else $error("window moved while its result was blocked");
`endif

endmodule
